### sv/fpdlw_pkg.sv
// Shared types and constants for the fixed-point decimal display writer.
`timescale 1ns / 1ps

package fpdlw_pkg;

  // Value format
  localparam int ValueWidth = 32;
  localparam int FracBits   = 16;

  // Integer digits are kept as packed BCD; the top digit overflow is dropped
  localparam int NumDigits = 4;
  localparam int BcdWidth  = 4 * NumDigits;

  // Register file
  localparam int AddrWidth = 4;
  localparam int DataWidth = 32;
  localparam int CfgWidth  = 3;

  localparam logic [1:0] RegIntDigits  = 2'd0;
  localparam logic [1:0] RegFracDigits = 2'd1;
  localparam logic [1:0] RegColumn     = 2'd2;

  localparam logic [CfgWidth-1:0] IntDigitsReset  = 3'd3;
  localparam logic [CfgWidth-1:0] FracDigitsReset = 3'd2;
  localparam logic [CfgWidth-1:0] ColumnReset     = 3'd4;

  // Frame sync bytes
  localparam logic [7:0] SyncCmd  = 8'hF8;
  localparam logic [7:0] SyncData = 8'hFA;

  // Characters
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [1:0]                   line;
  } in_t;

  typedef struct packed {
    logic [23:0] frame_word;
    logic        is_data;
    logic [7:0]  char_byte;
    logic        last;
  } out_t;

  // Clamped digit counts and column, as the sequencer uses them
  typedef struct packed {
    logic [CfgWidth-1:0] nint;
    logic [CfgWidth-1:0] nfrac;
    logic [CfgWidth-1:0] column;
  } cfg_t;

endpackage

### sv/fixed_point_decimal_lcd_writer_unit.sv
// Top level of the fixed-point decimal writer for a serial character display.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one beat carries a
//   signed fixed-point value and a display line. Output channel (out_valid_o /
//   out_stall_i / out_data_o): per input, one set-address command beat, then
//   one data beat per character: sign, int digits, '.', fraction digits.
//   The final beat of an input has last set; 3 + int + frac beats in total.
//   Registers (APB, byte address 4*i): int_digits, frac_digits, column.
// Timing
//   The integer part is converted one bit per cycle through a double-dabble
//   shift register. Beats then leave one per cycle while the output register
//   is free (not held by out_stall_i); fraction digits are made as they are
//   sent, one multiply-by-ten per digit. One input is handled at a time.
//   in_stall_o drops as soon as the last beat sits in the output register.
// Reset and stall
//   Reset returns the sequencer to idle, empties the output register and
//   restores int_digits 3, frac_digits 2, column 4.
//   While out_stall_i is high a held output beat stays and the sequence waits.

module fixed_point_decimal_lcd_writer_unit #(
  parameter int FRAC_BITS = fpdlw_pkg::FracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fpdlw_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fpdlw_pkg::out_t                 out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpdlw_pkg::AddrWidth-1:0] paddr,
  input  logic [fpdlw_pkg::DataWidth-1:0] pwdata,
  output logic [fpdlw_pkg::DataWidth-1:0] prdata,
  output logic                            pready
);

  localparam int VW       = fpdlw_pkg::ValueWidth;
  localparam int IntWidth = VW - FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e          state_q, state_d;
  fpdlw_pkg::cfg_t cfg;

  logic            in_accept;
  logic [VW-1:0]   raw, mag;
  logic            neg_q;
  logic [1:0]      line_q;

  logic                           conv_done;
  logic [fpdlw_pkg::BcdWidth-1:0] bcd;
  logic [3:0]                     frac_digit;
  logic                           frac_step;

  logic [2:0]      k_q, k_d;
  logic [2:0]      dot_slot, last_slot, di;
  logic            out_free, emit, is_last;
  logic [7:0]      char_b, sync_b;
  logic            is_data;
  logic            out_valid_q;
  fpdlw_pkg::out_t out_data_q;

  // ---------------------------------------------------------------- registers
  fpdlw_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // ---------------------------------------------------------------- input side
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Magnitude is exact for the most negative value (VW-bit unsigned)
  assign raw = in_data_i.value;
  assign mag = raw[VW-1] ? (~raw + {{(VW-1){1'b0}}, 1'b1}) : raw;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      neg_q  <= raw[VW-1];
      line_q <= in_data_i.line;
    end
  end

  fpdlw_int_conv #(
    .INT_WIDTH (IntWidth)
  ) u_int_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept),
    .int_bits_i (mag[VW-1:FRAC_BITS]),
    .done_o     (conv_done),
    .bcd_o      (bcd)
  );

  fpdlw_frac_gen #(
    .FRAC_BITS (FRAC_BITS)
  ) u_frac_gen (
    .clk_i   (clk_i),
    .load_i  (in_accept),
    .frac_i  (mag[FRAC_BITS-1:0]),
    .step_i  (frac_step),
    .digit_o (frac_digit)
  );

  // ---------------------------------------------------------------- sequencer
  // Slot k: 0 address command, 1 sign, 2..nint+1 int digits (high first),
  // nint+2 point, then fraction digits.
  assign dot_slot  = cfg.nint + 3'd2;
  assign last_slot = dot_slot + cfg.nfrac;
  assign di        = cfg.nint + 3'd1 - k_q;
  assign is_last   = (k_q == last_slot);

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == S_EMIT) && out_free;

  function automatic logic [7:0] line_base(input logic [1:0] ln);
    case (ln)
      2'd0:    return 8'h80;
      2'd1:    return 8'h90;
      2'd2:    return 8'h88;
      default: return 8'h98;
    endcase
  endfunction

  always_comb begin
    frac_step = 1'b0;
    is_data   = 1'b1;
    sync_b    = fpdlw_pkg::SyncData;
    if (k_q == 3'd0) begin
      is_data = 1'b0;
      sync_b  = fpdlw_pkg::SyncCmd;
      char_b  = line_base(line_q) + {5'b0, cfg.column};
    end else if (k_q == 3'd1) begin
      char_b = neg_q ? fpdlw_pkg::CharMinus : fpdlw_pkg::CharSpace;
    end else if (k_q < dot_slot) begin
      char_b = fpdlw_pkg::CharZero + {4'b0, bcd[di[1:0]*4 +: 4]};
    end else if (k_q == dot_slot) begin
      char_b = fpdlw_pkg::CharPoint;
    end else begin
      char_b    = fpdlw_pkg::CharZero + {4'b0, frac_digit};
      frac_step = emit;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CONV;
          k_d     = 3'd0;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          k_d = k_q + 3'd1;
          if (is_last) begin
            state_d = S_IDLE;
            k_d     = 3'd0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        k_d     = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= 3'd0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // ---------------------------------------------------------------- output reg
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.frame_word <= {sync_b, char_b[7:4], 4'b0000, char_b[3:0], 4'b0000};
      out_data_q.is_data    <= is_data;
      out_data_q.char_byte  <= char_b;
      out_data_q.last       <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Command beats always carry the command sync, data beats the data sync
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_data ?
      (out_data_o.frame_word[23:16] == fpdlw_pkg::SyncData) :
      (out_data_o.frame_word[23:16] == fpdlw_pkg::SyncCmd)))
    else $error("frame sync does not match beat type");

  // Sending the last beat frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && is_last |=> (state_q == S_IDLE) && !in_stall_o)
    else $error("sequencer not idle after last beat");

  // Double dabble keeps every digit in 0..9 once conversion is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (bcd[3:0] <= 4'd9) && (bcd[7:4] <= 4'd9) &&
      (bcd[11:8] <= 4'd9) && (bcd[15:12] <= 4'd9))
    else $error("BCD digit out of range");

  // A fraction digit is always a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_step |-> (frac_digit <= 4'd9))
    else $error("fraction digit out of range");

  // Beats are only produced while the sequence runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("beat produced outside emission");
`endif

endmodule

### sv/fpdlw_cfg_regs.sv
// APB register file with digit-count clamping.
`timescale 1ns / 1ps

module fpdlw_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [fpdlw_pkg::AddrWidth-1:0]  paddr_i,
  input  logic [fpdlw_pkg::DataWidth-1:0]  pwdata_i,
  output logic [fpdlw_pkg::DataWidth-1:0]  prdata_o,
  output logic                             pready_o,
  output fpdlw_pkg::cfg_t                  cfg_o
);

  logic [fpdlw_pkg::CfgWidth-1:0] int_digits_q, frac_digits_q, column_q;
  logic [fpdlw_pkg::CfgWidth-1:0] nint, nfrac_lim, nfrac;
  logic [1:0]                     reg_idx;
  logic                           wr_en;

  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[fpdlw_pkg::AddrWidth-1:2];
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_digits_q  <= fpdlw_pkg::IntDigitsReset;
      frac_digits_q <= fpdlw_pkg::FracDigitsReset;
      column_q      <= fpdlw_pkg::ColumnReset;
    end else if (wr_en) begin
      case (reg_idx)
        fpdlw_pkg::RegIntDigits:  int_digits_q  <= pwdata_i[fpdlw_pkg::CfgWidth-1:0];
        fpdlw_pkg::RegFracDigits: frac_digits_q <= pwdata_i[fpdlw_pkg::CfgWidth-1:0];
        fpdlw_pkg::RegColumn:     column_q      <= pwdata_i[fpdlw_pkg::CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fpdlw_pkg::RegIntDigits:
        prdata_o = {{(fpdlw_pkg::DataWidth-fpdlw_pkg::CfgWidth){1'b0}}, int_digits_q};
      fpdlw_pkg::RegFracDigits:
        prdata_o = {{(fpdlw_pkg::DataWidth-fpdlw_pkg::CfgWidth){1'b0}}, frac_digits_q};
      fpdlw_pkg::RegColumn:
        prdata_o = {{(fpdlw_pkg::DataWidth-fpdlw_pkg::CfgWidth){1'b0}}, column_q};
      default:
        prdata_o = '0;
    endcase
  end

  // int digits 1..4; frac digits at most 4 and at most 5 - int digits
  always_comb begin
    if (int_digits_q == 3'd0) begin
      nint = 3'd1;
    end else if (int_digits_q > 3'd4) begin
      nint = 3'd4;
    end else begin
      nint = int_digits_q;
    end
    nfrac_lim = 3'd5 - nint;
    nfrac     = (frac_digits_q > 3'd4) ? 3'd4 : frac_digits_q;
    if (nfrac > nfrac_lim) begin
      nfrac = nfrac_lim;
    end
  end

  assign cfg_o.nint   = nint;
  assign cfg_o.nfrac  = nfrac;
  assign cfg_o.column = column_q;

endmodule

### sv/fpdlw_int_conv.sv
// Bit-serial binary to BCD converter (double dabble), keeps the low four digits.
`timescale 1ns / 1ps

module fpdlw_int_conv #(
  parameter int INT_WIDTH = fpdlw_pkg::ValueWidth - fpdlw_pkg::FracBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [INT_WIDTH-1:0]           int_bits_i,
  output logic                           done_o,
  output logic [fpdlw_pkg::BcdWidth-1:0] bcd_o
);

  localparam int CntWidth = $clog2(INT_WIDTH + 1);

  logic [INT_WIDTH-1:0]           sreg_q, sreg_d;
  logic [CntWidth-1:0]            cnt_q, cnt_d;
  logic [fpdlw_pkg::BcdWidth-1:0] bcd_q, bcd_d, bcd_adj;

  function automatic logic [fpdlw_pkg::BcdWidth-1:0] dd_adjust(
    input logic [fpdlw_pkg::BcdWidth-1:0] b
  );
    logic [fpdlw_pkg::BcdWidth-1:0] r;
    r = b;
    for (int i = 0; i < fpdlw_pkg::NumDigits; i++) begin
      if (r[i*4 +: 4] >= 4'd5) begin
        r[i*4 +: 4] = r[i*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign bcd_adj = dd_adjust(bcd_q);

  always_comb begin
    sreg_d = sreg_q;
    cnt_d  = cnt_q;
    bcd_d  = bcd_q;
    if (load_i) begin
      sreg_d = int_bits_i;
      cnt_d  = CntWidth'(INT_WIDTH);
      bcd_d  = '0;
    end else if (cnt_q != '0) begin
      // MSB first; the bit leaving the top digit is the 10^4 place
      sreg_d = sreg_q << 1;
      cnt_d  = cnt_q - CntWidth'(1);
      bcd_d  = {bcd_adj[fpdlw_pkg::BcdWidth-2:0], sreg_q[INT_WIDTH-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
    bcd_q  <= bcd_d;
  end

  assign done_o = (cnt_q == '0);
  assign bcd_o  = bcd_q;

endmodule

### sv/fpdlw_frac_gen.sv
// Fraction digit generator: multiply by ten, one digit per step.
`timescale 1ns / 1ps

module fpdlw_frac_gen #(
  parameter int FRAC_BITS = fpdlw_pkg::FracBits
) (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  input  logic                 step_i,
  output logic [3:0]           digit_o
);

  logic [FRAC_BITS-1:0] frac_q;
  logic [FRAC_BITS+3:0] prod;

  // frac * 10 = frac * 8 + frac * 2
  assign prod = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};
  assign digit_o = prod[FRAC_BITS+3:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frac_q <= frac_i;
    end else if (step_i) begin
      frac_q <= prod[FRAC_BITS-1:0];
    end
  end

endmodule
